// File: src/kf2_pkg.sv
// Package: widths, fixed-point helpers and codes for the two-state Kalman filter.
`default_nettype none
package kf2_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int NUM_REGS = 7;
   localparam int IDX_BITS = 3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;

   localparam logic [IDX_BITS-1:0] REG_TRANS_00 = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_TRANS_01 = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_TRANS_10 = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_TRANS_11 = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_OBS_0    = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_OBS_1    = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_NOISE    = 3'd6;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SKIP = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   localparam logic OP_STEP = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type ONE = word_type'(64'sd1 <<< FRAC_BITS);

   // operand select codes for the shared unit
   typedef enum logic [4:0] {
      S_X0, S_X1, S_P0, S_P1, S_P2, S_P3, S_F0, S_F1, S_F2, S_F3,
      S_H0, S_H1, S_R, S_Z, S_U0, S_U1, S_T0, S_T1, S_T2, S_T3,
      S_K0, S_K1, S_Y, S_S, S_ONE, S_ZERO, S_A, S_B, S_M0, S_M1, S_M2, S_M3
   } sel_type;

   typedef struct packed {
      logic    mul;     // 1: product, 0: sum
      logic    neg_b;   // subtract b
      sel_type a;
      sel_type b;
      sel_type dst;
   } uop_type;

   function automatic word_type sat_prod(input prod_type v, output logic hit);
      prod_type hi, lo;
      hi = prod_type'(WORD_MAX);
      lo = prod_type'(WORD_MIN);
      hit = (v > hi) || (v < lo);
      if (v > hi) return WORD_MAX;
      if (v < lo) return WORD_MIN;
      return word_type'(v);
   endfunction
endpackage
`default_nettype wire

// File: src/kf2_if.sv
// Valid/ready channel interfaces for request, response and configuration words.
`default_nettype none
interface kf2_req_if;
   import kf2_pkg::*;
   logic valid, ready, opcode;
   word_type measurement, motion_0, motion_1, load_est_0, load_est_1;
   word_type load_cov_00, load_cov_01, load_cov_10, load_cov_11;
   modport source(output valid, opcode, measurement, motion_0, motion_1, load_est_0,
      load_est_1, load_cov_00, load_cov_01, load_cov_10, load_cov_11, input ready);
   modport sink(input valid, opcode, measurement, motion_0, motion_1, load_est_0,
      load_est_1, load_cov_00, load_cov_01, load_cov_10, load_cov_11, output ready);
endinterface

interface kf2_rsp_if;
   import kf2_pkg::*;
   logic valid, ready;
   word_type est_0, est_1, cov_00, cov_01, cov_10, cov_11;
   logic [1:0] status;
   modport source(output valid, est_0, est_1, cov_00, cov_01, cov_10, cov_11, status,
      input ready);
   modport sink(input valid, est_0, est_1, cov_00, cov_01, cov_10, cov_11, status,
      output ready);
endinterface

interface kf2_csr_if;
   import kf2_pkg::*;
   logic valid, ready;
   logic [IDX_BITS-1:0] index;
   word_type data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/kf2_alu.sv
// Shared unit: one registered multiply with round and saturate, or saturating add.
`default_nettype none
module kf2_alu (
   input  wire logic clock,
   input  wire logic start,
   input  wire logic mul,
   input  wire kf2_pkg::word_type a,
   input  wire kf2_pkg::word_type b,
   output kf2_pkg::word_type result,
   output logic sat
);
   import kf2_pkg::*;
   prod_type prod_ff, prod_in, sum;
   logic mul_ff, h;
   always_comb begin
      prod_in = mul ? prod_type'(a) * prod_type'(b) : prod_type'(a) + prod_type'(b);
      if (mul_ff) sum = (prod_ff + (prod_type'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
      else sum = prod_ff;
      result = sat_prod(sum, h);
      sat = h;
   end
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         mul_ff <= mul;
      end
   end
endmodule
`default_nettype wire

// File: src/kf2_div.sv
// Serial restoring divider for the gain: round(|n| * 2^FRAC / s), sign restored.
`default_nettype none
module kf2_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire kf2_pkg::word_type num,
   input  wire kf2_pkg::word_type den,
   output logic busy,
   output kf2_pkg::word_type quot,
   output logic sat
);
   import kf2_pkg::*;
   localparam int NB = WORD_BITS + FRAC_BITS + 1;
   localparam int CB = $clog2(NB + 1);
   logic [NB-1:0] dvd_ff, dvd_in, q_ff, q_in;
   logic [NB:0] rem_ff, rem_in, trial;
   logic [WORD_BITS-1:0] den_ff;
   logic [WORD_BITS:0] mag;
   logic neg_ff;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   prod_type qs;
   logic h;
   always_comb begin
      dvd_in = dvd_ff; q_in = q_ff; rem_in = rem_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff[NB-1:0], dvd_ff[NB-1]};
      mag = num[WORD_BITS-1] ? -{num[WORD_BITS-1], num} : {1'b0, num};
      if (start) begin
         // m*2^F + s/2, shifted through the divider
         dvd_in = (NB'(mag) << FRAC_BITS) + NB'(den >> 1);
         rem_in = '0; q_in = '0; cnt_in = CB'(NB); busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {{(NB+1-WORD_BITS){1'b0}}, den_ff}) begin
            rem_in = trial - {{(NB+1-WORD_BITS){1'b0}}, den_ff};
            q_in = {q_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) busy_in = 1'b0;
      end
      qs = prod_type'({1'b0, q_ff});
      if (neg_ff) qs = -qs;
      quot = sat_prod(qs, h);
      sat = h;
      busy = busy_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in; q_ff <= q_in; rem_ff <= rem_in;
      if (start) begin
         den_ff <= den;
         neg_ff <= num[WORD_BITS-1];
      end
   end
endmodule
`default_nettype wire

// File: src/kalman_filter_two_state_unit.sv
// Top level: register file, sequencer and state of the two-state Kalman filter.
// A step runs the shared-unit ops, one gain division per gain, the S test and a copy back
// of P; the correction is skipped when S is not positive. Requests are taken one at a time;
// req ready only while idle and no response pending.
// Reset (synchronous, active high) clears the state to zero and the registers to
// their defaults; no clearing pass.
`default_nettype none
module kalman_filter_two_state_unit (
   input wire logic clock,
   input wire logic reset,
   kf2_req_if.sink req,
   kf2_rsp_if.source rsp,
   kf2_csr_if.sink csr
);
   import kf2_pkg::*;

   typedef enum logic [6:0] {
      IDLE = 7'b0000001, ISSUE = 7'b0000010, WAIT = 7'b0000100, CHECK = 7'b0001000,
      DIVS = 7'b0010000, DIVW = 7'b0100000, DONE = 7'b1000000
   } state_type;

   localparam int PCB = 6;

   state_type state_ff, state_in;
   logic [PCB-1:0] pc_ff, pc_in;
   word_type rf_ff [32];
   logic [31:0] rf_we;
   word_type wr_val;
   word_type regs_ff [NUM_REGS];
   logic sat_ff, sat_in, skip_ff, skip_in, rsp_valid_ff, rsp_valid_in;
   logic dsel_ff, dsel_in;
   uop_type op;
   word_type alu_a, alu_b, alu_r, div_q;
   logic alu_sat, div_busy, div_sat, div_start, alu_start, cap_in;

   // program: correction (0..43) then prediction (44..)
   function automatic uop_type prog(input logic [PCB-1:0] i);
      uop_type u;
      u = '{1'b1, 1'b0, S_ZERO, S_ZERO, S_A};
      case (i)
         6'd0:  u = '{1'b1, 1'b0, S_H0, S_P0, S_A};
         6'd1:  u = '{1'b1, 1'b0, S_H1, S_P2, S_B};
         6'd2:  u = '{1'b0, 1'b0, S_A, S_B, S_T0};   // hp0
         6'd3:  u = '{1'b1, 1'b0, S_H0, S_P1, S_A};
         6'd4:  u = '{1'b1, 1'b0, S_H1, S_P3, S_B};
         6'd5:  u = '{1'b0, 1'b0, S_A, S_B, S_T1};   // hp1
         6'd6:  u = '{1'b1, 1'b0, S_T0, S_H0, S_A};
         6'd7:  u = '{1'b1, 1'b0, S_T1, S_H1, S_B};
         6'd8:  u = '{1'b0, 1'b0, S_A, S_B, S_S};
         6'd9:  u = '{1'b0, 1'b0, S_S, S_R, S_S};    // s, then check
         6'd10: u = '{1'b1, 1'b0, S_P0, S_H0, S_A};
         6'd11: u = '{1'b1, 1'b0, S_P1, S_H1, S_B};
         6'd12: u = '{1'b0, 1'b0, S_A, S_B, S_K0};   // n0, then divide
         6'd13: u = '{1'b1, 1'b0, S_P2, S_H0, S_A};
         6'd14: u = '{1'b1, 1'b0, S_P3, S_H1, S_B};
         6'd15: u = '{1'b0, 1'b0, S_A, S_B, S_K1};   // n1, then divide
         6'd16: u = '{1'b1, 1'b0, S_H0, S_X0, S_A};
         6'd17: u = '{1'b1, 1'b0, S_H1, S_X1, S_B};
         6'd18: u = '{1'b0, 1'b0, S_A, S_B, S_Y};
         6'd19: u = '{1'b0, 1'b1, S_Z, S_Y, S_Y};
         6'd20: u = '{1'b1, 1'b0, S_K0, S_Y, S_A};
         6'd21: u = '{1'b0, 1'b0, S_X0, S_A, S_X0};
         6'd22: u = '{1'b1, 1'b0, S_K1, S_Y, S_A};
         6'd23: u = '{1'b0, 1'b0, S_X1, S_A, S_X1};
         6'd24: u = '{1'b1, 1'b0, S_K0, S_H0, S_A};
         6'd25: u = '{1'b0, 1'b1, S_ONE, S_A, S_M0};
         6'd26: u = '{1'b1, 1'b0, S_K0, S_H1, S_A};
         6'd27: u = '{1'b0, 1'b1, S_ZERO, S_A, S_M1};
         6'd28: u = '{1'b1, 1'b0, S_K1, S_H0, S_A};
         6'd29: u = '{1'b0, 1'b1, S_ZERO, S_A, S_M2};
         6'd30: u = '{1'b1, 1'b0, S_K1, S_H1, S_A};
         6'd31: u = '{1'b0, 1'b1, S_ONE, S_A, S_M3};
         6'd32: u = '{1'b1, 1'b0, S_M0, S_P0, S_A};
         6'd33: u = '{1'b1, 1'b0, S_M1, S_P2, S_B};
         6'd34: u = '{1'b0, 1'b0, S_A, S_B, S_T0};
         6'd35: u = '{1'b1, 1'b0, S_M0, S_P1, S_A};
         6'd36: u = '{1'b1, 1'b0, S_M1, S_P3, S_B};
         6'd37: u = '{1'b0, 1'b0, S_A, S_B, S_T1};
         6'd38: u = '{1'b1, 1'b0, S_M2, S_P0, S_A};
         6'd39: u = '{1'b1, 1'b0, S_M3, S_P2, S_B};
         6'd40: u = '{1'b0, 1'b0, S_A, S_B, S_T2};
         6'd41: u = '{1'b1, 1'b0, S_M2, S_P1, S_A};
         6'd42: u = '{1'b1, 1'b0, S_M3, S_P3, S_B};
         6'd43: u = '{1'b0, 1'b0, S_A, S_B, S_P3};  // then copy t0..t2 into p
         // prediction, x
         6'd44: u = '{1'b1, 1'b0, S_F0, S_X0, S_A};
         6'd45: u = '{1'b1, 1'b0, S_F1, S_X1, S_B};
         6'd46: u = '{1'b0, 1'b0, S_A, S_B, S_M0};
         6'd47: u = '{1'b0, 1'b0, S_M0, S_U0, S_M0};
         6'd48: u = '{1'b1, 1'b0, S_F2, S_X0, S_A};
         6'd49: u = '{1'b1, 1'b0, S_F3, S_X1, S_B};
         6'd50: u = '{1'b0, 1'b0, S_A, S_B, S_M1};
         6'd51: u = '{1'b0, 1'b0, S_M1, S_U1, S_X1};  // then x0 = m0
         default: u = '{1'b1, 1'b0, S_ZERO, S_ZERO, S_A};
      endcase
      return u;
   endfunction

   // covariance prediction runs as a second pass: t = F p, then p = t F^T
   logic [3:0] cp_ff, cp_in;
   logic [1:0] cph_ff, cph_in;
   uop_type cop;
   always_comb begin
      // cp: entry index (i,j) = cp[1],cp[0]; cp[2]: 0 for t, 1 for p
      cop = '{1'b1, 1'b0, S_ZERO, S_ZERO, S_A};
      if (!cp_ff[2]) begin
         case (cph_ff)
            2'd0: cop = '{1'b1, 1'b0, cp_ff[1] ? S_F2 : S_F0, cp_ff[0] ? S_P1 : S_P0, S_A};
            2'd1: cop = '{1'b1, 1'b0, cp_ff[1] ? S_F3 : S_F1, cp_ff[0] ? S_P3 : S_P2, S_B};
            default: cop = '{1'b0, 1'b0, S_A, S_B,
               sel_type'(5'(S_T0) + 5'(cp_ff[1:0]))};
         endcase
      end else begin
         case (cph_ff)
            2'd0: cop = '{1'b1, 1'b0, cp_ff[1] ? S_T2 : S_T0, cp_ff[0] ? S_F2 : S_F0, S_A};
            2'd1: cop = '{1'b1, 1'b0, cp_ff[1] ? S_T3 : S_T1, cp_ff[0] ? S_F3 : S_F1, S_B};
            default: cop = '{1'b0, 1'b0, S_A, S_B,
               sel_type'(5'(S_M0) + 5'(cp_ff[1:0]))};
         endcase
      end
   end

   logic in_cov_ff, in_cov_in;
   localparam logic [PCB-1:0] PC_PRED = 6'd44;
   localparam logic [PCB-1:0] PC_END = 6'd52;

   function automatic word_type rd(input sel_type s, input word_type r[32],
                                   input word_type g[NUM_REGS]);
      case (s)
         S_F0: return g[0];
         S_F1: return g[1];
         S_F2: return g[2];
         S_F3: return g[3];
         S_H0: return g[4];
         S_H1: return g[5];
         S_R:  return g[6];
         S_ONE: return ONE;
         S_ZERO: return '0;
         default: return r[s];
      endcase
   endfunction

   always_comb begin
      op = in_cov_ff ? cop : prog(pc_ff);
      alu_a = rd(op.a, rf_ff, regs_ff);
      alu_b = rd(op.b, rf_ff, regs_ff);
      if (op.neg_b) alu_b = alu_b == WORD_MIN ? WORD_MAX : -alu_b;
   end
   // negation of the minimum clamps; to keep a - MIN exact, widen instead
   word_type nb_a;
   logic neg_min;
   assign neg_min = op.neg_b && (rd(op.b, rf_ff, regs_ff) == WORD_MIN);
   assign nb_a = alu_a;

   word_type alu_b_eff;
   logic extra_sat;
   always_comb begin
      // a - MIN exceeds range unless a < 0; emulate a + 2^31 with a + MAX + 1
      alu_b_eff = alu_b;
      extra_sat = 1'b0;
      if (neg_min) begin
         if (nb_a[WORD_BITS-1]) alu_b_eff = alu_b; // a + MAX then +1 below
         else extra_sat = 1'b1;
      end
   end

   word_type alu_out;
   logic alu_out_sat, fix_ff;
   kf2_alu u_alu (
      .clock(clock), .start(alu_start), .mul(op.mul),
      .a(neg_min && nb_a[WORD_BITS-1] ? nb_a + word_type'(1) : nb_a),
      .b(alu_b_eff), .result(alu_r), .sat(alu_sat)
   );
   assign alu_out = fix_ff ? WORD_MAX : alu_r;
   assign alu_out_sat = alu_sat || fix_ff;

   kf2_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(rf_ff[dsel_ff ? S_K1 : S_K0]), .den(rf_ff[S_S]),
      .busy(div_busy), .quot(div_q), .sat(div_sat)
   );

   logic req_fire, csr_fire, rsp_fire;
   assign req_fire = req.valid && req.ready;
   assign csr_fire = csr.valid && csr.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign req.ready = (state_ff == IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.est_0 = rf_ff[S_X0];
   assign rsp.est_1 = rf_ff[S_X1];
   assign rsp.cov_00 = rf_ff[S_P0];
   assign rsp.cov_01 = rf_ff[S_P1];
   assign rsp.cov_10 = rf_ff[S_P2];
   assign rsp.cov_11 = rf_ff[S_P3];
   assign rsp.status = skip_ff ? ST_SKIP : (sat_ff ? ST_SAT : ST_OK);

   sel_type wdst;
   logic fix_in;
   always_comb begin
      state_in = state_ff; pc_in = pc_ff; sat_in = sat_ff; skip_in = skip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire; dsel_in = dsel_ff;
      cp_in = cp_ff; cph_in = cph_ff; in_cov_in = in_cov_ff;
      alu_start = 1'b0; div_start = 1'b0; cap_in = 1'b0; rf_we = '0; wr_val = alu_out;
      wdst = op.dst; fix_in = 1'b0;
      case (state_ff)
         IDLE: begin
            if (req_fire) begin
               sat_in = 1'b0; skip_in = 1'b0;
               if (req.opcode == OP_LOAD) begin
                  cap_in = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  cap_in = 1'b1;
                  pc_in = '0; in_cov_in = 1'b0;
                  state_in = ISSUE;
               end
            end
         end
         ISSUE: begin
            alu_start = 1'b1;
            fix_in = extra_sat;
            state_in = WAIT;
         end
         WAIT: begin
            rf_we[wdst] = 1'b1;
            sat_in = sat_ff || alu_out_sat;
            state_in = ISSUE;
            if (in_cov_ff) begin
               if (cph_ff == 2'd2) begin
                  cph_in = '0;
                  if (cp_ff == 4'd7) state_in = DONE;
                  cp_in = cp_ff + 1'b1;
               end else cph_in = cph_ff + 1'b1;
            end else begin
               pc_in = pc_ff + 1'b1;
               if (pc_ff == 6'd9) state_in = CHECK;
               if (pc_ff == 6'd12) begin state_in = DIVS; dsel_in = 1'b0; end
               if (pc_ff == 6'd15) begin state_in = DIVS; dsel_in = 1'b1; end
               if (pc_ff == 6'd43) begin
                  rf_we[S_P0] = 1'b1; rf_we[S_P1] = 1'b1; rf_we[S_P2] = 1'b1;
               end
               if (pc_ff == PC_END - 1'b1) begin
                  rf_we[S_X0] = 1'b1;
                  in_cov_in = 1'b1; cp_in = '0; cph_in = '0;
               end
            end
         end
         CHECK: begin
            state_in = ISSUE;
            if (rf_ff[S_S][WORD_BITS-1] || rf_ff[S_S] == '0) begin
               skip_in = 1'b1;
               pc_in = PC_PRED;
            end
         end
         DIVS: begin
            div_start = 1'b1;
            state_in = DIVW;
         end
         DIVW: begin
            if (!div_busy) begin
               rf_we[dsel_ff ? S_K1 : S_K0] = 1'b1;
               wdst = dsel_ff ? S_K1 : S_K0;
               wr_val = div_q;
               sat_in = sat_ff || div_sat;
               state_in = ISSUE;
            end
         end
         DONE: begin
            rf_we[S_P0] = 1'b1; rf_we[S_P1] = 1'b1; rf_we[S_P2] = 1'b1; rf_we[S_P3] = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE; pc_ff <= '0; rsp_valid_ff <= 1'b0; sat_ff <= 1'b0;
         skip_ff <= 1'b0; dsel_ff <= 1'b0; cp_ff <= '0; cph_ff <= '0;
         in_cov_ff <= 1'b0; fix_ff <= 1'b0;
         regs_ff[0] <= ONE; regs_ff[1] <= ONE; regs_ff[2] <= '0; regs_ff[3] <= ONE;
         regs_ff[4] <= ONE; regs_ff[5] <= '0; regs_ff[6] <= ONE;
         for (int i = 0; i < 32; i++) rf_ff[i] <= '0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; rsp_valid_ff <= rsp_valid_in;
         sat_ff <= sat_in; skip_ff <= skip_in; dsel_ff <= dsel_in;
         cp_ff <= cp_in; cph_ff <= cph_in; in_cov_ff <= in_cov_in;
         if (alu_start) fix_ff <= fix_in;
         if (csr_fire && csr.index < IDX_BITS'(NUM_REGS)) begin
            if (csr.index == REG_NOISE) regs_ff[csr.index] <= {1'b0, csr.data[WORD_BITS-2:0]};
            else regs_ff[csr.index] <= csr.data;
         end
         for (int i = 0; i < 32; i++) begin
            if (rf_we[i]) begin
               if (state_ff == DONE && i >= S_P0 && i <= S_P3) rf_ff[i] <= rf_ff[S_M0 + i - S_P0];
               else if (state_ff == WAIT && !in_cov_ff && pc_ff == 6'd43 && i >= S_P0
                        && i <= S_P2) rf_ff[i] <= rf_ff[S_T0 + i - S_P0];
               else if (state_ff == WAIT && !in_cov_ff && pc_ff == PC_END - 1'b1
                        && i == S_X0) rf_ff[i] <= rf_ff[S_M0];
               else rf_ff[i] <= wr_val;
            end
         end
         if (cap_in) begin
            rf_ff[S_Z] <= req.measurement;
            rf_ff[S_U0] <= req.motion_0;
            rf_ff[S_U1] <= req.motion_1;
            if (req.opcode == OP_LOAD) begin
               rf_ff[S_X0] <= req.load_est_0; rf_ff[S_X1] <= req.load_est_1;
               rf_ff[S_P0] <= req.load_cov_00; rf_ff[S_P1] <= req.load_cov_01;
               rf_ff[S_P2] <= req.load_cov_10; rf_ff[S_P3] <= req.load_cov_11;
            end
         end
      end
   end
endmodule
`default_nettype wire
